// File: src/rlgc_pkg.sv
package rlgc_pkg;

  localparam int FRAC_BITS = 12;
  localparam int MAX_RUN   = 16;
  localparam int SAMPLE_W  = 8;
  localparam int STEP_W    = 16;
  localparam int GAIN_W    = 16;
  localparam int POS_W     = 17;
  localparam int PSUM_W    = POS_W + 2;
  localparam int RUN_W     = $clog2(MAX_RUN + 1);
  localparam int ACC_W     = SAMPLE_W + FRAC_BITS + 1;
  localparam int PROD_W    = SAMPLE_W + GAIN_W + 2;
  localparam int CFG_IDX_W = 8;
  localparam int MID_LEVEL = 128;

  localparam logic [POS_W-1:0]         ONE        = POS_W'(1 << FRAC_BITS);
  localparam logic [PSUM_W-1:0]        TWO_ONE    = PSUM_W'(2 << FRAC_BITS);
  localparam logic [PSUM_W-1:0]        FOUR_ONE   = PSUM_W'(4 << FRAC_BITS);
  localparam logic [STEP_W-1:0]        STEP_RST   = STEP_W'(6144);
  localparam logic [GAIN_W-1:0]        GAIN_RST   = GAIN_W'(512);
  localparam logic signed [PROD_W-1:0] CLIP_LIM   = PROD_W'(MID_LEVEL * 256);
  localparam logic [SAMPLE_W:0]        MID_EXT    = (SAMPLE_W + 1)'(MID_LEVEL);
  localparam logic [SAMPLE_W-1:0]      SAMPLE_MAX = '1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RATE_STEP = CFG_IDX_W'(0),
    REG_GAIN      = CFG_IDX_W'(1)
  } reg_idx_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;     // input word taken this cycle
    logic issue;      // push one position into the result pipe
    logic hold;       // issued value is the current sample, not interpolated
    logic adv_pos;    // position += step
    logic wrap;       // position -= one, run count cleared
    logic flush_out;  // move pending result to output with end flags
    logic commit;     // end of item: update stream state
  } rlgc_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic have_prev;
    logic last;
    logic pos_ge_one;
    logic done_hit;
    logic run_full;
    logic hold_ok;
    logic adv;
    logic out_free;
    logic pipe_empty;
    logic pend_v;
  } rlgc_stat_t;

endpackage

// File: src/rlgc_ctrl.sv
module rlgc_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  rlgc_pkg::rlgc_stat_t stat,
  output rlgc_pkg::rlgc_cmd_t  cmd
);
  import rlgc_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_INTERP = 5'b00010,
    S_SKIP   = 5'b00100,
    S_HOLD   = 5'b01000,
    S_FLUSH  = 5'b10000
  } state_t;

  state_t state_r, state_nxt;

  assign in_tready = (state_r == S_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.accept = 1'b1;
          if (stat.have_prev) begin
            state_nxt = S_INTERP;
          end else if (stat.last) begin
            state_nxt = S_HOLD;
          end
        end
      end
      S_INTERP: begin
        priority if (stat.pos_ge_one) begin
          cmd.wrap  = 1'b1;
          state_nxt = stat.last ? S_HOLD : S_FLUSH;
        end else if (stat.done_hit) begin
          state_nxt = S_FLUSH;
        end else if (stat.run_full) begin
          state_nxt = S_SKIP;
        end else if (stat.adv) begin
          cmd.issue   = 1'b1;
          cmd.adv_pos = 1'b1;
        end
      end
      S_SKIP: begin
        // run cap hit: step past the remaining positions of this interval
        if (stat.pos_ge_one) begin
          cmd.wrap  = 1'b1;
          state_nxt = stat.last ? S_HOLD : S_FLUSH;
        end else begin
          cmd.adv_pos = 1'b1;
        end
      end
      S_HOLD: begin
        if (!stat.hold_ok) begin
          state_nxt = S_FLUSH;
        end else if (stat.adv) begin
          cmd.issue   = 1'b1;
          cmd.hold    = 1'b1;
          cmd.adv_pos = 1'b1;
        end
      end
      S_FLUSH: begin
        if (stat.pipe_empty) begin
          if (!stat.pend_v) begin
            cmd.commit = 1'b1;
            state_nxt  = S_IDLE;
          end else if (stat.out_free) begin
            cmd.flush_out = 1'b1;
            cmd.commit    = 1'b1;
            state_nxt     = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: src/rlgc_dp.sv
module rlgc_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic [rlgc_pkg::SAMPLE_W-1:0]          in_sample,
  input  logic                                   in_last,
  input  logic                                   cfg_we,
  input  logic [rlgc_pkg::CFG_IDX_W-1:0]         cfg_idx,
  input  logic [rlgc_pkg::STEP_W-1:0]            cfg_wdata,
  input  rlgc_pkg::rlgc_cmd_t                    cmd,
  output rlgc_pkg::rlgc_stat_t                   stat,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [rlgc_pkg::SAMPLE_W-1:0]          out_sample,
  output logic                                   out_clipped,
  output logic                                   out_clip_seen,
  output logic                                   out_last_run,
  output logic                                   out_stream_end
);
  import rlgc_pkg::*;

  logic [STEP_W-1:0]   rate_step_r;
  logic [GAIN_W-1:0]   gain_r;
  logic [SAMPLE_W-1:0] prev_r, prev_nxt;
  logic                have_r, have_nxt;
  logic [POS_W-1:0]    next_pos_r, next_pos_nxt;
  logic                sticky_r, sticky_nxt;
  logic [SAMPLE_W-1:0] s_r;
  logic                last_r;
  logic [POS_W-1:0]    pos_r, pos_nxt;
  logic [RUN_W-1:0]    run_r, run_nxt;

  logic                x_v_r, v_v_r, pend_v_r, out_v_r;
  logic                x_v_nxt, v_v_nxt, pend_v_nxt, out_v_nxt;
  logic [SAMPLE_W-1:0] x_r;
  logic signed [PROD_W-1:0] v_r;
  logic [SAMPLE_W-1:0] pend_y_r;
  logic                pend_clip_r, pend_seen_r;
  logic [SAMPLE_W-1:0] out_y_r;
  logic                out_clip_r, out_seen_r, out_lor_r, out_end_r;

  logic [POS_W-1:0]    step_e;
  logic [PSUM_W-1:0]   sum2;
  logic                run_full, adv, out_free;
  logic [FRAC_BITS:0]  inv_w;
  logic [ACC_W-1:0]    acc;
  logic [SAMPLE_W-1:0] x_nxt;
  logic signed [SAMPLE_W:0] diff;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] biased;
  logic [SAMPLE_W-1:0] y;
  logic                clip;
  logic                pend_load, out_from_pend;

  assign step_e   = (rate_step_r == '0) ? POS_W'(1) : POS_W'(rate_step_r);
  assign sum2     = {1'b0, pos_r, 1'b0} + PSUM_W'(step_e);
  assign run_full = (run_r >= RUN_W'(MAX_RUN));
  assign out_free = !out_v_r || out_ready;
  assign adv      = !pend_v_r || out_free;

  assign stat.have_prev  = have_r;
  assign stat.last       = cmd.accept ? in_last : last_r;
  assign stat.pos_ge_one = (pos_r >= ONE);
  assign stat.done_hit   = last_r && (sum2 > FOUR_ONE);
  assign stat.run_full   = run_full;
  assign stat.hold_ok    = (sum2 <= TWO_ONE) && !run_full;
  assign stat.adv        = adv;
  assign stat.out_free   = out_free;
  assign stat.pipe_empty = !x_v_r && !v_v_r;
  assign stat.pend_v     = pend_v_r;

  // interpolation: position is below one whenever it is used here
  assign inv_w = (FRAC_BITS + 1)'(ONE - pos_r);
  assign acc   = ACC_W'(prev_r) * ACC_W'(inv_w)
               + ACC_W'(s_r) * ACC_W'(pos_r[FRAC_BITS-1:0]);
  assign x_nxt = cmd.hold ? s_r : acc[FRAC_BITS +: SAMPLE_W];

  assign diff = $signed({1'b0, x_r} - MID_EXT);
  assign prod = PROD_W'(diff) * $signed(PROD_W'({1'b0, gain_r}));

  always_comb begin
    biased = v_r + CLIP_LIM;
    clip   = 1'b0;
    priority if (v_r > CLIP_LIM) begin
      y    = SAMPLE_MAX;
      clip = 1'b1;
    end else if (v_r < -CLIP_LIM) begin
      y    = '0;
      clip = 1'b1;
    end else if (biased[SAMPLE_W+8]) begin
      // exactly +128 maps to 256, held at full scale without a clip
      y = SAMPLE_MAX;
    end else begin
      y = biased[8 +: SAMPLE_W];
    end
  end

  assign pend_load     = adv && v_v_r;
  assign out_from_pend = pend_load && pend_v_r;

  always_comb begin
    x_v_nxt    = adv ? cmd.issue : x_v_r;
    v_v_nxt    = adv ? x_v_r : v_v_r;
    pend_v_nxt = pend_v_r;
    if (pend_load) begin
      pend_v_nxt = 1'b1;
    end else if (cmd.flush_out) begin
      pend_v_nxt = 1'b0;
    end
    out_v_nxt = out_v_r;
    if (out_from_pend || cmd.flush_out) begin
      out_v_nxt = 1'b1;
    end else if (out_ready) begin
      out_v_nxt = 1'b0;
    end
    sticky_nxt = sticky_r | (pend_load && clip);
  end

  always_comb begin
    pos_nxt      = pos_r;
    run_nxt      = run_r;
    prev_nxt     = prev_r;
    have_nxt     = have_r;
    next_pos_nxt = next_pos_r;
    if (cmd.accept) begin
      pos_nxt = next_pos_r;
      run_nxt = '0;
      if (!have_r && !in_last) begin
        prev_nxt = in_sample;
        have_nxt = 1'b1;
      end
    end
    if (cmd.adv_pos) begin
      pos_nxt = pos_r + step_e;
    end
    if (cmd.issue) begin
      run_nxt = run_r + RUN_W'(1);
    end
    if (cmd.wrap) begin
      pos_nxt = pos_r - ONE;
      run_nxt = '0;
    end
    if (cmd.commit) begin
      prev_nxt     = last_r ? '0 : s_r;
      have_nxt     = !last_r;
      next_pos_nxt = last_r ? '0 : pos_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rate_step_r <= STEP_RST;
      gain_r      <= GAIN_RST;
      prev_r      <= '0;
      have_r      <= 1'b0;
      next_pos_r  <= '0;
      sticky_r    <= 1'b0;
      pos_r       <= '0;
      run_r       <= '0;
      x_v_r       <= 1'b0;
      v_v_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_v_r     <= 1'b0;
    end else begin
      if (cfg_we && cfg_idx == REG_RATE_STEP) begin
        rate_step_r <= cfg_wdata;
      end
      if (cfg_we && cfg_idx == REG_GAIN) begin
        gain_r <= cfg_wdata;
      end
      prev_r     <= prev_nxt;
      have_r     <= have_nxt;
      next_pos_r <= next_pos_nxt;
      sticky_r   <= sticky_nxt;
      pos_r      <= pos_nxt;
      run_r      <= run_nxt;
      x_v_r      <= x_v_nxt;
      v_v_r      <= v_v_nxt;
      pend_v_r   <= pend_v_nxt;
      out_v_r    <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      s_r    <= in_sample;
      last_r <= in_last;
    end
    if (adv && cmd.issue) begin
      x_r <= x_nxt;
    end
    if (adv && x_v_r) begin
      v_r <= prod;
    end
    if (pend_load) begin
      pend_y_r    <= y;
      pend_clip_r <= clip;
      pend_seen_r <= sticky_r | clip;
    end
    if (out_from_pend || cmd.flush_out) begin
      out_y_r    <= pend_y_r;
      out_clip_r <= pend_clip_r;
      out_seen_r <= pend_seen_r;
      out_lor_r  <= cmd.flush_out;
      out_end_r  <= cmd.flush_out && last_r;
    end
  end

  assign out_valid      = out_v_r;
  assign out_sample     = out_y_r;
  assign out_clipped    = out_clip_r;
  assign out_clip_seen  = out_seen_r;
  assign out_last_run   = out_lor_r;
  assign out_stream_end = out_end_r;

endmodule

// File: src/resample_lerp_gain_clip.sv
// Linear-interpolation resampler with gain about mid-level and clipping.
// Input stream: one unsigned 8-bit sample per word on in_tdata, in_tlast
// marks the final sample of a stream. Output stream: one resampled sample
// per word on out_tdata; out_tlast marks the last word caused by an input
// word, out_tuser carries the clip flag, the sticky clip flag and the
// end-of-stream flag. Config port: index 0 writes rate_step (Q4.12),
// index 1 writes gain (Q8.8); other indexes are dropped. Write only idle.
// Timing: one input word is processed at a time. After the accept cycle
// the block issues one output position per cycle while the output is not
// stalled (interpolate, then gain multiply, then clamp, two register
// stages), then drains the result pipe. Each result passes x_r and v_r,
// waits in the pending register and then moves to the output register;
// with no stall the words follow one per cycle.
// When the run cap cuts an interval short, the position
// counter steps once per cycle up to the next sample.
// A first sample that is not marked last gives nothing.
// Reset restores rate_step 6144, gain 512 and clears the stream state and
// the sticky clip flag. Once a word is pending, a stalled receiver freezes
// the result pipe; one finished word waits in the output register while
// the next is held pending, and in_tready stays low until the item's last
// word has reached the output register.
module resample_lerp_gain_clip (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [7:0]                          in_tdata,   // [7:0] sample_in
  input  logic                                in_tlast,
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [7:0]                          out_tdata,  // [7:0] sample_out
  output logic                                out_tlast,
  output logic [2:0]                          out_tuser,  // clipped, clip_seen, stream_end
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [rlgc_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [15:0]                         cfg_data
);
  import rlgc_pkg::*;

  rlgc_cmd_t  cmd;
  rlgc_stat_t stat;
  logic       clipped, clip_seen, stream_end;

  assign cfg_ready = 1'b1;

  rlgc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .stat      (stat),
    .cmd       (cmd)
  );

  rlgc_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_sample      (in_tdata),
    .in_last        (in_tlast),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_idx        (cfg_index),
    .cfg_wdata      (cfg_data),
    .cmd            (cmd),
    .stat           (stat),
    .out_valid      (out_tvalid),
    .out_ready      (out_tready),
    .out_sample     (out_tdata),
    .out_clipped    (clipped),
    .out_clip_seen  (clip_seen),
    .out_last_run   (out_tlast),
    .out_stream_end (stream_end)
  );

  assign out_tuser = {stream_end, clip_seen, clipped};

endmodule

// File: tb/resample_lerp_gain_clip_tb.sv
module resample_lerp_gain_clip_tb;
  import rlgc_pkg::*;

  localparam int RESULT_CAP  = 32;
  localparam int CYCLE_LIMIT = 6_000_000;
  localparam int RAND_ITEMS  = 300;
  localparam int RAND_WORDS  = 48;
  localparam int DIR_N       = 33;

  // where a directed row gets its expected words
  localparam int EXP_MODEL = -1;
  localparam int EXP_NONE  = 0;
  localparam int EXP_ONE   = 1;

  // indexes the block must drop
  localparam logic [CFG_IDX_W-1:0] REG_SPARE   = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_TOP_IDX = '1;

  typedef struct packed {
    logic [7:0] smp;
    logic       clipped;
    logic       seen;
    logic       run_last;
    logic       strm_end;
  } word_t;

  typedef enum logic {ROW_CFG, ROW_SMP} row_kind_t;

  typedef struct packed {
    row_kind_t            kind;
    logic [CFG_IDX_W-1:0] idx;
    logic [15:0]          val;
    logic [7:0]           smp;
    logic                 lst;
    int                   n_exp;
    word_t                exp_word;
  } row_t;

  localparam word_t NO_WORD = '0;

  logic                 clk = 1'b0;
  logic                 rst_n;
  logic                 in_tvalid;
  logic                 in_tready;
  logic [7:0]           in_tdata;
  logic                 in_tlast;
  logic                 out_tvalid;
  logic                 out_tready = 1'b0;
  logic [7:0]           out_tdata;
  logic                 out_tlast;
  logic [2:0]           out_tuser;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [15:0]          cfg_data;

  // predictor state
  logic [15:0]      step_q;
  logic [15:0]      gain_q;
  logic [7:0]       prev_q;
  bit               have_prev_q;
  logic [POS_W-1:0] next_pos_q;
  bit               sticky_q;

  word_t due_words[$];
  int    errors;
  int    cycles;
  int    burst_left;
  bit    steady;
  int    rand_items;
  int    rand_words;
  bit [5:0] rx_tick;
  bit [1:0] rx_mode;

  row_t dir_rows [DIR_N] = '{
    '{ROW_SMP, '0, 16'd0, 8'd0, 1'b0, EXP_NONE, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd255, 1'b0, EXP_ONE, '{8'd0, 1'b1, 1'b1, 1'b1, 1'b0}},
    '{ROW_SMP, '0, 16'd0, 8'd128, 1'b1, EXP_MODEL, NO_WORD},
    '{ROW_CFG, REG_GAIN, 16'd256, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_CFG, REG_RATE_STEP, 16'd4096, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd128, 1'b0, EXP_NONE, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd255, 1'b1, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd7, 1'b1, EXP_ONE, '{8'd7, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_CFG, REG_GAIN, 16'd512, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd192, 1'b1, EXP_ONE, '{8'd255, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_SMP, '0, 16'd0, 8'd64, 1'b1, EXP_ONE, '{8'd0, 1'b0, 1'b1, 1'b1, 1'b1}},
    '{ROW_CFG, REG_GAIN, 16'd0, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd0, 1'b0, EXP_NONE, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd255, 1'b1, EXP_MODEL, NO_WORD},
    '{ROW_CFG, REG_GAIN, 16'hFFFF, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd129, 1'b0, EXP_NONE, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd127, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd128, 1'b1, EXP_MODEL, NO_WORD},
    '{ROW_CFG, REG_RATE_STEP, 16'hFFFF, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd200, 1'b1, EXP_NONE, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd10, 1'b0, EXP_NONE, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd20, 1'b1, EXP_NONE, NO_WORD},
    '{ROW_CFG, REG_RATE_STEP, 16'd0, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_CFG, REG_GAIN, 16'd256, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd0, 1'b0, EXP_NONE, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd255, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd100, 1'b1, EXP_MODEL, NO_WORD},
    '{ROW_CFG, REG_RATE_STEP, 16'd256, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_CFG, REG_SPARE, 16'd0, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_CFG, REG_TOP_IDX, 16'hFFFF, 8'd0, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd50, 1'b0, EXP_NONE, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd60, 1'b0, EXP_MODEL, NO_WORD},
    '{ROW_SMP, '0, 16'd0, 8'd70, 1'b1, EXP_MODEL, NO_WORD}
  };

  always #4 clk = ~clk;

  resample_lerp_gain_clip u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // gain about mid-level, then clamp; updates the sticky flag
  function automatic word_t gain_clamp(input logic [7:0] s);
    word_t w;
    int    v;
    int    y;
    w = '0;
    v = (int'(s) - MID_LEVEL) * int'(gain_q);
    if (v > MID_LEVEL * 256) begin
      w.clipped = 1'b1;
      w.smp     = 8'hFF;
    end else if (v < -MID_LEVEL * 256) begin
      w.clipped = 1'b1;
      w.smp     = 8'h00;
    end else begin
      y = (v + MID_LEVEL * 256) >>> 8;
      if (y > 255) y = 255;
      w.smp = y[7:0];
    end
    if (w.clipped) sticky_q = 1'b1;
    w.seen = sticky_q;
    return w;
  endfunction

  // words caused by one input sample
  task automatic resample_word(input logic [7:0] s, input bit lst, output word_t res[$]);
    longint unsigned one;
    longint unsigned stp;
    longint unsigned pos;
    longint unsigned acc;
    int              run;
    bit              done;
    one  = 64'd1 << FRAC_BITS;
    stp  = (step_q == 16'd0) ? 64'd1 : 64'(step_q);
    pos  = 64'(next_pos_q);
    done = 1'b0;
    res  = {};
    if (!have_prev_q) begin
      if (!lst) begin
        prev_q      = s;
        have_prev_q = 1'b1;
        return;
      end
    end else begin
      run = 0;
      while (pos < one) begin
        if (lst && 2 * pos + stp > 4 * one) begin
          done = 1'b1;
          break;
        end
        // run cap: the rest of the interval is skipped
        if (run >= MAX_RUN || res.size() >= RESULT_CAP) begin
          pos += stp * ((one - pos + stp - 1) / stp);
          break;
        end
        acc = 64'(prev_q) * (one - pos) + 64'(s) * pos;
        res.push_back(gain_clamp(8'(acc >> FRAC_BITS)));
        run++;
        pos += stp;
      end
      if (!done) pos -= one;
      prev_q = s;
    end
    // hold the final sample while the end rule admits positions
    if (lst && !done) begin
      run = 0;
      while (2 * pos + stp <= 2 * one && run < MAX_RUN && res.size() < RESULT_CAP) begin
        res.push_back(gain_clamp(s));
        run++;
        pos += stp;
      end
    end
    if (lst) begin
      prev_q      = '0;
      have_prev_q = 1'b0;
      next_pos_q  = '0;
    end else begin
      next_pos_q = pos[POS_W-1:0];
    end
    if (res.size() > 0) begin
      res[res.size()-1].run_last = 1'b1;
      res[res.size()-1].strm_end = lst;
    end
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val,
                           input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_RATE_STEP) step_q = val;
    else if (idx == REG_GAIN) gain_q = val;
    if (!more) cfg_valid <= 1'b0;
  endtask

  // drain, then give the block time to finish skipping positions
  task automatic settle();
    int eff;
    in_tvalid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    eff = (step_q == 16'd0) ? 1 : int'(step_q);
    repeat ((1 << FRAC_BITS) / eff + 64) @(posedge clk);
  endtask

  task automatic send_word(input logic [7:0] s, input bit lst);
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= lst;
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic pace();
    int gap;
    if (steady) return;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 16);
    end
  endtask

  task automatic feed(input logic [7:0] s, input bit lst);
    word_t w[$];
    send_word(s, lst);
    resample_word(s, lst, w);
    foreach (w[k]) due_words.push_back(w[k]);
    rand_items++;
    rand_words += w.size();
    pace();
  endtask

  task automatic report_field(input string name, input int want, input int got);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
    errors++;
  endtask

  // receiver stalls on a mode that changes whenever rx_tick wraps to zero
  always @(posedge clk) begin
    rx_tick <= rx_tick + 6'd1;
    if (rx_tick == 6'd0) rx_mode <= 2'($urandom_range(0, 3));
    case (rx_mode)
      2'd0: out_tready <= 1'b1;
      2'd1: out_tready <= 1'($urandom_range(0, 1));
      2'd2: out_tready <= (rx_tick[1:0] == 2'd0);
      default: out_tready <= ($urandom_range(0, 9) < 2);
    endcase
  end

  always @(posedge clk) begin
    word_t got;
    word_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.smp      = out_tdata;
      got.clipped  = out_tuser[0];
      got.seen     = out_tuser[1];
      got.run_last = out_tlast;
      got.strm_end = out_tuser[2];
      if (due_words.size() == 0) begin
        $display("%0t: word with nothing expected, got %p", $time, got);
        errors++;
      end else begin
        want = due_words.pop_front();
        if (got.smp !== want.smp) report_field("sample_out", want.smp, got.smp);
        if (got.clipped !== want.clipped) report_field("clipped", want.clipped, got.clipped);
        if (got.seen !== want.seen) report_field("clip_seen", want.seen, got.seen);
        if (got.run_last !== want.run_last)
          report_field("last_of_run", want.run_last, got.run_last);
        if (got.strm_end !== want.strm_end)
          report_field("stream_end", want.strm_end, got.strm_end);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("resample_lerp_gain_clip_tb: FAIL");
      $finish;
    end
  end

  initial begin
    row_t        r;
    word_t       w[$];
    bit          more;
    logic [15:0] stp;
    logic [15:0] gn;
    int          phase_items;
    int          n;
    int          stream_len;
    rst_n     <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata  <= '0;
    in_tlast  <= 1'b0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    step_q      = STEP_RST;
    gain_q      = GAIN_RST;
    prev_q      = '0;
    have_prev_q = 1'b0;
    next_pos_q  = '0;
    sticky_q    = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    for (int i = 0; i < DIR_N; i++) begin
      r = dir_rows[i];
      if (r.kind == ROW_CFG) begin
        if (i == 0 || dir_rows[i-1].kind != ROW_CFG) settle();
        more = (i + 1 < DIR_N) && (dir_rows[i+1].kind == ROW_CFG);
        write_reg(r.idx, r.val, more);
      end else begin
        send_word(r.smp, r.lst);
        resample_word(r.smp, r.lst, w);
        if (r.n_exp == EXP_MODEL) begin
          foreach (w[k]) due_words.push_back(w[k]);
        end else if (r.n_exp == EXP_ONE) begin
          due_words.push_back(r.exp_word);
        end
        pace();
      end
    end

    while (rand_items < RAND_ITEMS || rand_words < RAND_WORDS) begin
      settle();
      case ($urandom_range(0, 7))
        0: stp = 16'd256;
        1: stp = 16'hFFFF;
        2: stp = 16'($urandom_range(0, 255));
        3: stp = 16'($urandom_range(256, 65535));
        default: stp = 16'($urandom_range(256, 8192));
      endcase
      case ($urandom_range(0, 5))
        0: gn = 16'd0;
        1: gn = 16'hFFFF;
        2: gn = 16'($urandom);
        default: gn = 16'($urandom_range(64, 1024));
      endcase
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_W'($urandom_range(2, 255)), 16'($urandom), 1'b1);
      write_reg(REG_RATE_STEP, stp, 1'b1);
      write_reg(REG_GAIN, gn, 1'b0);
      steady = ($urandom_range(0, 3) == 0);
      // sub-1/16 steps crawl through skipped positions, keep those phases short
      phase_items = (stp < 16'd256) ? 4 : $urandom_range(10, 40);
      n = 0;
      while (n < phase_items) begin
        stream_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 12);
        if (stp < 16'd256 && stream_len > 3) stream_len = 3;
        for (int k = 0; k < stream_len; k++) begin
          feed(8'($urandom), k == stream_len - 1);
          n++;
        end
      end
    end

    settle();
    if (errors == 0) begin
      $display("resample_lerp_gain_clip_tb: PASS");
    end else begin
      $display("resample_lerp_gain_clip_tb: FAIL");
    end
    $finish;
  end

endmodule
